### design/becm_pkg.sv
package becm_pkg;

   localparam int DrawWidth  = 16;
   localparam int PhaseWidth = 16;
   localparam int IndexWidth = 3;

   typedef enum logic [1:0] {
      GOOD_STABLE   = 2'd0,
      BAD_STABLE    = 2'd1,
      BAD_UNSTABLE  = 2'd2,
      GOOD_UNSTABLE = 2'd3
   } chan_state_type;

   typedef enum logic [IndexWidth-1:0] {
      REG_GOOD_UNS_TO_BAD = 3'd0,
      REG_GOOD_S_TO_BAD   = 3'd1,
      REG_BAD_UNS_TO_GOOD = 3'd2,
      REG_BAD_S_TO_GOOD   = 3'd3,
      REG_BITS_PER_CYCLE  = 3'd4
   } reg_index_type;

   typedef enum logic {
      CMD_FRAME_START = 1'b0,
      CMD_NEXT_BIT    = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [DrawWidth-1:0]  good_uns_to_bad;
      logic [DrawWidth-1:0]  good_s_to_bad;
      logic [DrawWidth-1:0]  bad_uns_to_good;
      logic [DrawWidth-1:0]  bad_s_to_good;
      logic [PhaseWidth-1:0] bits_per_cycle;
   } cfg_type;

   typedef struct packed {
      logic           erased;
      logic           data_out;
      chan_state_type chan_state;
   } result_type;

   function automatic logic is_bad(chan_state_type st);
      return (st == BAD_STABLE) || (st == BAD_UNSTABLE);
   endfunction

endpackage

### design/becm_csr.sv
module becm_csr
   import becm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DrawWidth-1:0]  csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_GOOD_UNS_TO_BAD: cfg_in.good_uns_to_bad = csr_data;
            REG_GOOD_S_TO_BAD:   cfg_in.good_s_to_bad   = csr_data;
            REG_BAD_UNS_TO_GOOD: cfg_in.bad_uns_to_good = csr_data;
            REG_BAD_S_TO_GOOD:   cfg_in.bad_s_to_good   = csr_data;
            REG_BITS_PER_CYCLE:  cfg_in.bits_per_cycle  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.good_uns_to_bad <= '0;
         cfg_ff.good_s_to_bad   <= '0;
         cfg_ff.bad_uns_to_good <= '0;
         cfg_ff.bad_s_to_good   <= '0;
         cfg_ff.bits_per_cycle  <= PhaseWidth'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/becm_core.sv
module becm_core
   import becm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 cmd,
   input  logic [DrawWidth-1:0] draw,
   input  logic                 data_bit,
   input  cfg_type              cfg,
   output result_type           result
);

   chan_state_type        state_ff, state_in, trans_state;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [PhaseWidth-1:0] limit;
   logic [PhaseWidth:0]   phase_inc;
   logic                  wrap;

   assign limit     = (cfg.bits_per_cycle == '0) ? PhaseWidth'(1) : cfg.bits_per_cycle;
   assign phase_inc = {1'b0, phase_ff} + (PhaseWidth+1)'(1);
   assign wrap      = phase_inc >= {1'b0, limit};

   always_comb begin
      unique case (state_ff)
         GOOD_STABLE:   trans_state = (draw < cfg.good_s_to_bad)   ? BAD_UNSTABLE  : GOOD_STABLE;
         BAD_STABLE:    trans_state = (draw < cfg.bad_s_to_good)   ? GOOD_UNSTABLE : BAD_STABLE;
         BAD_UNSTABLE:  trans_state = (draw < cfg.bad_uns_to_good) ? GOOD_UNSTABLE : BAD_STABLE;
         GOOD_UNSTABLE: trans_state = (draw < cfg.good_uns_to_bad) ? BAD_UNSTABLE  : GOOD_STABLE;
         default:       trans_state = GOOD_STABLE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      if (accept) begin
         if (cmd_type'(cmd) == CMD_FRAME_START) begin
            // quarter of the draw range picks the start state
            state_in = chan_state_type'(draw[DrawWidth-1 -: 2]);
            phase_in = '0;
         end else if (wrap) begin
            state_in = trans_state;
            phase_in = '0;
         end else begin
            phase_in = phase_inc[PhaseWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GOOD_STABLE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign result.chan_state = state_in;
   assign result.erased     = is_bad(state_in);
   assign result.data_out   = data_bit | is_bad(state_in);

endmodule

### design/becm_out.sv
module becm_out
   import becm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_result,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       accept, take;

   assign in_ready   = !skid_valid_ff;
   assign accept     = in_valid && in_ready;
   assign take       = out_valid_ff && out_ready;
   assign out_valid  = out_valid_ff;
   assign out_result = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = in_result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = in_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transfer while output is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && out_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("stalled transfer not captured in skid");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (out_valid_ff && out_ff == $past(skid_ff)))
      else $error("skid entry lost or reordered");

   a_erase_forces_data: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.erased) |-> out_ff.data_out)
      else $error("erased bit not forced high");

   a_erase_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.erased == is_bad(out_ff.chan_state)))
      else $error("erasure flag disagrees with channel state");

endmodule

### design/burst_erasure_channel_model_top.sv
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tuser: cmd; tdata: random_draw, data_bit
// rsp      out  rsp_tvalid/tready     tuser: erased; tdata: data_out, channel_state_out
// csr      in   csr_valid/csr_ready   csr_index, csr_data
//
// One item per cycle while req_tready is high: state and bit phase update at the
// req transfer and the result is registered before it appears on rsp.
// A two-entry output (register plus skid) takes one req transfer into the skid
// entry while rsp stalls; req_tready is low while it is full. csr_ready is always high.
// Synchronous reset: good-stable, phase zero, probabilities zero, bits_per_cycle 1.
module burst_erasure_channel_model_top
   import becm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,  // [15:0] random_draw, [16] data_bit, rest zero
   input  logic                  req_tuser,  // [0] cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // [0] data_out, [2:1] channel_state_out, rest zero
   output logic                  rsp_tuser,  // [0] erased
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DrawWidth-1:0]  csr_data
);

   cfg_type    cfg;
   result_type core_result;
   result_type out_result;
   logic       accept;

   assign accept = req_tvalid && req_tready;

   becm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   becm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (req_tuser),
      .draw     (req_tdata[DrawWidth-1:0]),
      .data_bit (req_tdata[DrawWidth]),
      .cfg      (cfg),
      .result   (core_result)
   );

   becm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_result  (core_result),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tuser = out_result.erased;
   assign rsp_tdata = {5'b0, out_result.chan_state, out_result.data_out};

endmodule
